// ----- src/array_linked_list_engine_core_macros.svh -----
// assertion helpers used by the checker file
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ALLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ALLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/alle_pkg.sv -----
`default_nettype none
package alle_pkg;

	localparam int SLOTS      = 64;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int VAL_W      = 32;
	localparam int IN_DATA_W  = ((SLOT_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_FLDS_W = 2 + 4 * SLOT_W;
	localparam int OUT_DATA_W = ((OUT_FLDS_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_DEL_RD,
		STEP_INS_W1,
		STEP_INS_W2,
		STEP_DEL_W1,
		STEP_DEL_W2
	} dp_step_t;

	typedef struct packed {
		logic     take;
		dp_step_t step;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic early_err;
		logic in_del;
		logic v_none;
		logic out_free;
	} dp_sts_t;

	// successor link of a slot right after reset: free chain 1..SLOTS-1
	function automatic logic [SLOT_W-1:0] next_init(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W-1:0] res;
		if (idx == '0 || idx == SLOT_W'(SLOTS - 1)) begin
			res = '0;
		end else begin
			res = idx + SLOT_W'(1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- src/alle_ctrl.sv -----
`default_nettype none
module alle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output alle_pkg::dp_cmd_t cmd,
	input  alle_pkg::dp_sts_t sts
);
	import alle_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL_RD,
		S_INS_W1,
		S_INS_W2,
		S_DEL_W1,
		S_DEL_W2,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.take     = (state_q == S_IDLE) && in_valid;
		cmd.load_out = (state_q == S_FIN) && sts.out_free;
		unique case (state_q)
			S_DEL_RD: cmd.step = STEP_DEL_RD;
			S_INS_W1: cmd.step = STEP_INS_W1;
			S_INS_W2: cmd.step = STEP_INS_W2;
			S_DEL_W1: cmd.step = STEP_DEL_W1;
			S_DEL_W2: cmd.step = STEP_DEL_W2;
			default:  cmd.step = STEP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (sts.early_err) state_q <= S_FIN;
						else if (sts.in_del) state_q <= S_DEL_RD;
						else state_q <= S_INS_W1;
					end
				end
				S_DEL_RD: begin
					// anchor is the tail: nothing to remove
					if (sts.v_none) state_q <= S_FIN;
					else state_q <= S_DEL_W1;
				end
				S_INS_W1: state_q <= S_INS_W2;
				S_INS_W2: state_q <= S_FIN;
				S_DEL_W1: state_q <= S_DEL_W2;
				S_DEL_W2: state_q <= S_FIN;
				S_FIN: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/alle_dp.sv -----
`default_nettype none
module alle_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  alle_pkg::dp_cmd_t                 cmd,
	output alle_pkg::dp_sts_t                 sts,
	input  logic                              in_del,
	input  logic [alle_pkg::SLOT_W-1:0]       in_a,
	input  logic [alle_pkg::VAL_W-1:0]        in_val,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [alle_pkg::OUT_DATA_W-1:0]   out_data
);
	import alle_pkg::*;

	// link and value memories
	logic [SLOT_W-1:0] nmem [SLOTS];
	logic [SLOT_W-1:0] pmem [SLOTS];
	logic [VAL_W-1:0]  vmem [SLOTS];

	logic [SLOTS-1:0]  nvld_q, pvld_q, used_q;
	logic [SLOT_W-1:0] fh_q, first_q, last_q, cnt_q;
	logic              out_valid_q;

	logic [SLOT_W-1:0] a_q, v_q, res_slot_q;
	logic [VAL_W-1:0]  val_q;
	st_t               res_st_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// registered read ports
	logic [SLOT_W-1:0] rda_mem_q, rda_addr_q, rdb_mem_q, rdb_addr_q, rdp_mem_q;
	logic              rda_vld_q, rdb_vld_q, rdp_vld_q;

	logic [SLOT_W-1:0] nxt_a, nxt_b, prv, v_now, n_ins, n_del, rda_addr;
	logic              anchor_ok, rda_en, rd_v;
	st_t               early;

	logic              nwe, pwe, vwe;
	logic [SLOT_W-1:0] nwaddr, nwdata, pwaddr, pwdata, vwaddr;
	logic [VAL_W-1:0]  vwdata;

	assign nxt_a = rda_vld_q ? rda_mem_q : next_init(rda_addr_q);
	assign nxt_b = rdb_vld_q ? rdb_mem_q : next_init(rdb_addr_q);
	assign prv   = rdp_vld_q ? rdp_mem_q : '0;

	assign v_now = (a_q == '0) ? first_q : nxt_a;
	assign n_ins = (a_q == '0) ? first_q : nxt_a;
	assign n_del = nxt_a;

	assign rd_v     = (cmd.step == STEP_DEL_RD);
	assign rda_en   = cmd.take || rd_v;
	assign rda_addr = cmd.take ? in_a : v_now;

	assign anchor_ok = (in_a == '0) || used_q[in_a];

	always_comb begin
		if (!in_del) begin
			if (!anchor_ok) early = ST_BADPOS;
			else if (fh_q == '0) early = ST_FULL;
			else early = ST_OK;
		end else begin
			if (cnt_q == '0) early = ST_EMPTY;
			else if (!anchor_ok) early = ST_BADPOS;
			else early = ST_OK;
		end
	end

	assign sts.early_err = (early != ST_OK);
	assign sts.in_del    = in_del;
	assign sts.v_none    = (v_now == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// write ports
	always_comb begin
		nwe    = 1'b0;
		nwaddr = '0;
		nwdata = '0;
		pwe    = 1'b0;
		pwaddr = '0;
		pwdata = '0;
		vwe    = 1'b0;
		vwaddr = '0;
		vwdata = '0;
		case (cmd.step)
			STEP_INS_W1: begin
				nwe    = 1'b1;
				nwaddr = fh_q;
				nwdata = n_ins;
				pwe    = 1'b1;
				pwaddr = fh_q;
				pwdata = a_q;
				vwe    = 1'b1;
				vwaddr = fh_q;
				vwdata = val_q;
			end
			STEP_INS_W2: begin
				nwe    = (a_q != '0);
				nwaddr = a_q;
				nwdata = fh_q;
				pwe    = (n_ins != '0);
				pwaddr = n_ins;
				pwdata = fh_q;
			end
			STEP_DEL_W1: begin
				// freed slot goes on top of the free stack
				nwe    = 1'b1;
				nwaddr = v_q;
				nwdata = fh_q;
				pwe    = (n_del != '0);
				pwaddr = n_del;
				pwdata = prv;
			end
			STEP_DEL_W2: begin
				nwe    = (prv != '0);
				nwaddr = prv;
				nwdata = n_del;
				pwe    = 1'b1;
				pwaddr = v_q;
				pwdata = '0;
				vwe    = 1'b1;
				vwaddr = v_q;
				vwdata = '0;
			end
			default: begin
				nwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwe) nmem[nwaddr] <= nwdata;
		if (pwe) pmem[pwaddr] <= pwdata;
		if (vwe) vmem[vwaddr] <= vwdata;
		if (rda_en) begin
			rda_mem_q  <= nmem[rda_addr];
			rda_vld_q  <= nvld_q[rda_addr];
			rda_addr_q <= rda_addr;
		end
		if (cmd.take) begin
			rdb_mem_q  <= nmem[fh_q];
			rdb_vld_q  <= nvld_q[fh_q];
			rdb_addr_q <= fh_q;
		end
		if (rd_v) begin
			rdp_mem_q <= pmem[v_now];
			rdp_vld_q <= pvld_q[v_now];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_q      <= '0;
			pvld_q      <= '0;
			used_q      <= '0;
			fh_q        <= SLOT_W'(1);
			first_q     <= '0;
			last_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (nwe) nvld_q[nwaddr] <= 1'b1;
			if (pwe) pvld_q[pwaddr] <= 1'b1;
			if (cmd.step == STEP_INS_W2) begin
				fh_q           <= nxt_b;
				used_q[fh_q]   <= 1'b1;
				cnt_q          <= cnt_q + SLOT_W'(1);
				if (a_q == '0) first_q <= fh_q;
				if (n_ins == '0) last_q <= fh_q;
			end
			if (cmd.step == STEP_DEL_W2) begin
				fh_q         <= v_q;
				used_q[v_q]  <= 1'b0;
				cnt_q        <= cnt_q - SLOT_W'(1);
				if (prv == '0) first_q <= n_del;
				if (n_del == '0) last_q <= prv;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			a_q        <= in_a;
			val_q      <= in_val;
			res_st_q   <= early;
			res_slot_q <= '0;
		end
		if (rd_v) begin
			v_q <= v_now;
			if (v_now == '0) res_st_q <= ST_BADPOS;
		end
		if (cmd.step == STEP_INS_W2) res_slot_q <= fh_q;
		if (cmd.step == STEP_DEL_W2) res_slot_q <= v_q;
		if (cmd.load_out) begin
			out_data_q <= OUT_DATA_W'({cnt_q, last_q, first_q, res_slot_q, res_st_q});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ----- src/array_linked_list_engine_core.sv -----
// channel   direction  signals                    contents
// s_axis    in         tvalid tready tdata tuser  tuser: action; tdata: after_slot, value
// m_axis    out        tvalid tready tdata        tdata: status, slot, head, tail, count
//
// one item at a time: an insert steps INS_W1, INS_W2, FIN, a delete DEL_RD, DEL_W1,
// DEL_W2, FIN; an item rejected on entry goes to FIN, a delete with nothing after its
// anchor DEL_RD, FIN; one write port per link memory, up to two writes to each per item
// result sits in an output register; a stalled output only holds the finishing step
// asynchronous reset brings up an empty list with the free stack 1..63, no clearing pass
`default_nettype none
module array_linked_list_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [5:0] after_slot, [37:6] value, [39:38] zero
	input  logic [alle_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] action
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [1:0] status, [7:2] slot, [13:8] head_slot, [19:14] tail_slot, [25:20] count,
	// [31:26] zero
	output logic [alle_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import alle_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	alle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	alle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_del    (s_axis_tuser),
		.in_a      (s_axis_tdata[SLOT_W-1:0]),
		.in_val    (s_axis_tdata[SLOT_W +: VAL_W]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- src/alle_checker.sv -----
`default_nettype none
`include "array_linked_list_engine_core_macros.svh"
module alle_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [alle_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import alle_pkg::*;

	`ALLE_ASSERT_IMP(a_err_no_slot, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK), m_axis_tdata[7:2] == '0, "error result names a slot")
	`ALLE_ASSERT_IMP(a_ok_has_slot, m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK), m_axis_tdata[7:2] != '0, "ok result without a slot")
	`ALLE_ASSERT_IMP(a_empty_match, m_axis_tvalid, ((m_axis_tdata[13:8] == '0) == (m_axis_tdata[25:20] == '0)) && ((m_axis_tdata[19:14] == '0) == (m_axis_tdata[25:20] == '0)), "head, tail and count disagree on empty list")
	`ALLE_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new item taken while one is in work")
	`ALLE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (.*);
`default_nettype wire
